// ----- hdl/cddn_pkg.sv -----
// Package for the civil date / day number converter.
// Holds field widths, calendar constants, reciprocal-multiply constants and
// the month-start table. No dependencies.
package cddn_pkg;

  // Field widths of the input and result words
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned DN_BITS   = 25;

  // Signed width of the year used by the arithmetic
  localparam int unsigned YEAR_BITS = 16;

  // Pipeline depth
  localparam int unsigned NSTG = 8;

  // Calendar constants
  localparam int unsigned DAY_OFS   = 719468;   // 0000-03-01 to 1970-01-01
  localparam int unsigned ERA_DAYS  = 146097;   // days in 400 years
  localparam int unsigned ERA_LAST  = 146096;
  localparam int unsigned DOE_BITS  = 18;
  localparam int unsigned DOY_BITS  = 9;
  localparam int unsigned YOE_BITS  = 9;
  localparam int unsigned MP_BITS   = 4;

  // Date to day number: year biased by whole eras so it is never negative
  localparam int unsigned YP_BITS   = YEAR_BITS + 1;
  localparam int unsigned U_BITS    = YP_BITS;
  localparam int unsigned ERA_OFS_Y = ((1 << (YEAR_BITS - 1)) + 1 + 399) / 400;
  localparam int unsigned U_OFS     = 400 * ERA_OFS_Y;
  localparam int unsigned EY_BITS   = U_BITS - 8;
  localparam int unsigned EYS_BITS  = EY_BITS + 1;
  localparam int unsigned ED_BITS   = EYS_BITS + DOE_BITS;
  localparam int unsigned ZW        = ED_BITS + 1;

  // Day number to date: day count biased by whole eras
  localparam int unsigned W_BITS    = DN_BITS + 1;
  localparam int unsigned ERA_OFS_D =
    ((1 << (DN_BITS - 1)) - DAY_OFS + ERA_DAYS - 1) / ERA_DAYS;
  localparam int unsigned W_OFS     = DAY_OFS + ERA_DAYS * ERA_OFS_D;
  localparam int unsigned EU_BITS   = W_BITS - 17;
  localparam int unsigned ES_BITS   = EU_BITS + 1;
  localparam int unsigned YB_BITS   = ES_BITS + 10;

  // Reciprocal constants: q = (x * M) >> K, exact for x < 2**xbits when
  // K = xbits + clog2(divisor) and M = ceil(2**K / divisor).
  localparam int unsigned    Q400_K  = U_BITS + 9;
  localparam int unsigned    Q400_MW = U_BITS + 2;
  localparam int unsigned    Q400_PW = U_BITS + Q400_MW;
  localparam longint unsigned Q400_M = ((longint'(1) << Q400_K) + 399) / 400;

  localparam int unsigned    QERA_K  = W_BITS + 18;
  localparam int unsigned    QERA_MW = W_BITS + 2;
  localparam int unsigned    QERA_PW = W_BITS + QERA_MW;
  localparam longint unsigned QERA_M =
    ((longint'(1) << QERA_K) + ERA_DAYS - 1) / ERA_DAYS;

  localparam int unsigned    Q1460_K  = DOE_BITS + 11;
  localparam int unsigned    Q1460_PW = 2 * DOE_BITS + 2;
  localparam longint unsigned Q1460_M = ((longint'(1) << Q1460_K) + 1459) / 1460;

  localparam int unsigned    Q36524_K  = DOE_BITS + 16;
  localparam int unsigned    Q36524_PW = 2 * DOE_BITS + 2;
  localparam longint unsigned Q36524_M =
    ((longint'(1) << Q36524_K) + 36523) / 36524;

  localparam int unsigned    Q365_K  = DOE_BITS + 9;
  localparam int unsigned    Q365_PW = 2 * DOE_BITS + 2;
  localparam longint unsigned Q365_M = ((longint'(1) << Q365_K) + 364) / 365;

  localparam int unsigned    Q100_K  = YOE_BITS + 7;
  localparam int unsigned    Q100_PW = 2 * YOE_BITS + 2;
  localparam longint unsigned Q100_M = ((longint'(1) << Q100_K) + 99) / 100;

  localparam int unsigned    MPX_BITS = 11;
  localparam int unsigned    Q153_K  = MPX_BITS + 8;
  localparam int unsigned    Q153_PW = 2 * MPX_BITS + 2;
  localparam longint unsigned Q153_M = ((longint'(1) << Q153_K) + 152) / 153;

  // First day of year (March based) for each shifted month
  function automatic logic [DOY_BITS-1:0] month_start(input logic [MP_BITS-1:0] mp);
    logic [DOY_BITS-1:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/cddn_in_if.sv -----
// Input channel of the date converter: valid/ready plus one request word.
// Depends on cddn_pkg for field widths.
interface cddn_in_if import cddn_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [YEAR_W-1:0]  year_in;
  logic [MONTH_W-1:0]        month_in;
  logic [DAY_W-1:0]          day_in;
  logic signed [DN_BITS-1:0] day_number_in;

  modport source (output valid, func, year_in, month_in, day_in, day_number_in,
                  input ready);
  modport sink   (input valid, func, year_in, month_in, day_in, day_number_in,
                  output ready);
endinterface

// ----- hdl/cddn_out_if.sv -----
// Output channel of the date converter: valid/ready plus one result word.
// Depends on cddn_pkg for field widths.
interface cddn_out_if import cddn_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [DN_BITS-1:0] day_number_out;
  logic signed [YEAR_W-1:0]  year_out;
  logic [MONTH_W-1:0]        month_out;
  logic [DAY_W-1:0]          day_out;
  logic                      range_error;

  modport source (output valid, day_number_out, year_out, month_out, day_out,
                  range_error, input ready);
  modport sink   (input valid, day_number_out, year_out, month_out, day_out,
                  range_error, output ready);
endinterface

// ----- hdl/civil_date_day_number_converter_top.sv -----
// Top level of the civil date / day number converter.
// Depends on cddn_pkg, cddn_in_if and cddn_out_if.

// Converts proleptic Gregorian dates to signed days since 1970-01-01 (func 0)
// and back (func 1), using the 400-year era method with floor division so
// negative years and day counts are exact. The block is an 8-stage pipeline:
// one word is accepted every cycle when the output side keeps up; the depth
// is set by the chain of constant-reciprocal multiplies (era, years-of-era,
// day-of-year, month). Each stage holds its word while the stage after it is
// full and stalled, so bubbles close up and the input stays ready as long as
// any stage is free. range_error flags a bad month, a day of zero, or a result
// that does not fit its field; flagged results carry zeros. Days past the end
// of a short month roll into the next.
module civil_date_day_number_converter_top import cddn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cddn_in_if.sink     in_i,
  cddn_out_if.source  out_o
);

  // Stage words; date path and day-count path run side by side
  typedef struct packed {
    logic                  func;
    logic [U_BITS-1:0]     u;
    logic [DOY_BITS-1:0]   doy;
    logic                  bad;
    logic [W_BITS-1:0]     w;
  } st1_t;

  typedef struct packed {
    logic                  func;
    logic [U_BITS-1:0]     u;
    logic [EY_BITS-1:0]    q;
    logic [DOY_BITS-1:0]   doy;
    logic                  bad;
    logic [W_BITS-1:0]     w;
    logic [EU_BITS-1:0]    eu;
  } st2_t;

  typedef struct packed {
    logic                       func;
    logic [YOE_BITS-1:0]        yoe;
    logic signed [EYS_BITS-1:0] era;
    logic [DOY_BITS-1:0]        doy;
    logic                       bad;
    logic [DOE_BITS-1:0]        n_doe;
    logic signed [ES_BITS-1:0]  n_era;
  } st3_t;

  typedef struct packed {
    logic                       func;
    logic [DOE_BITS-1:0]        doe;
    logic signed [ED_BITS-1:0]  eday;
    logic                       bad;
    logic [DOE_BITS-1:0]        n_t;
    logic [DOE_BITS-1:0]        n_doe;
    logic signed [YB_BITS-1:0]  n_e400;
  } st4_t;

  typedef struct packed {
    logic                       func;
    logic [DN_BITS-1:0]         dn;
    logic                       derr;
    logic [YOE_BITS-1:0]        n_yoe;
    logic [DOE_BITS-1:0]        n_doe;
    logic signed [YB_BITS-1:0]  n_e400;
  } st5_t;

  typedef struct packed {
    logic                       func;
    logic [DN_BITS-1:0]         dn;
    logic                       derr;
    logic [DOY_BITS-1:0]        n_doy;
    logic signed [YB_BITS-1:0]  n_yb;
  } st6_t;

  typedef struct packed {
    logic                       func;
    logic [DN_BITS-1:0]         dn;
    logic                       derr;
    logic [MP_BITS-1:0]         n_mp;
    logic [DOY_BITS-1:0]        n_doy;
    logic signed [YB_BITS-1:0]  n_yb;
  } st7_t;

  typedef struct packed {
    logic [DN_BITS-1:0]  dn;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic                err;
  } st8_t;

  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  st4_t s4_d, s4_q;
  st5_t s5_d, s5_q;
  st6_t s6_d, s6_q;
  st7_t s7_d, s7_q;
  st8_t s8_d, s8_q;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   en;

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NSTG] = out_o.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign vld_in     = {vld_q[NSTG-2:0], in_i.valid};
  assign in_i.ready = en[0];

  // Stage 0 -> 1: month shift, era bias of the year, day-count bias
  always_comb begin
    logic [MONTH_W-1:0]        m;
    logic [MP_BITS-1:0]        mp;
    logic signed [YEAR_BITS-1:0] ysx;
    logic signed [YP_BITS-1:0] yp;
    m   = in_i.month_in;
    mp  = (m > 4'd2) ? MP_BITS'(m - 4'd3) : MP_BITS'(m + 4'd9);
    ysx = $signed(YEAR_BITS'($unsigned(in_i.year_in)));
    yp  = YP_BITS'(ysx) - ((m <= 4'd2) ? YP_BITS'(1) : YP_BITS'(0));
    s1_d.func = in_i.func;
    s1_d.u    = U_BITS'(yp) + U_BITS'(U_OFS);
    s1_d.doy  = month_start(mp) + DOY_BITS'(in_i.day_in) - DOY_BITS'(1);
    s1_d.bad  = (m < 4'd1) || (m > 4'd12) || (in_i.day_in == '0);
    s1_d.w    = W_BITS'(in_i.day_number_in) + W_BITS'(W_OFS);
  end

  // Stage 1 -> 2: era quotients by reciprocal multiply
  always_comb begin
    logic [Q400_PW-1:0] p400;
    logic [QERA_PW-1:0] pera;
    p400 = Q400_PW'(s1_q.u) * Q400_PW'(Q400_M);
    pera = QERA_PW'(s1_q.w) * QERA_PW'(QERA_M);
    s2_d.func = s1_q.func;
    s2_d.u    = s1_q.u;
    s2_d.q    = p400[Q400_K +: EY_BITS];
    s2_d.doy  = s1_q.doy;
    s2_d.bad  = s1_q.bad;
    s2_d.w    = s1_q.w;
    s2_d.eu   = pera[QERA_K +: EU_BITS];
  end

  // Stage 2 -> 3: remainders and unbiased eras
  always_comb begin
    s3_d.func  = s2_q.func;
    s3_d.yoe   = YOE_BITS'(s2_q.u - U_BITS'(s2_q.q) * U_BITS'(400));
    s3_d.era   = EYS_BITS'(s2_q.q) - EYS_BITS'(ERA_OFS_Y);
    s3_d.doy   = s2_q.doy;
    s3_d.bad   = s2_q.bad;
    s3_d.n_doe = DOE_BITS'(s2_q.w - W_BITS'(s2_q.eu) * W_BITS'(ERA_DAYS));
    s3_d.n_era = ES_BITS'(s2_q.eu) - ES_BITS'(ERA_OFS_D);
  end

  // Stage 3 -> 4: day of era (date path), leap-corrected day of era (days path)
  always_comb begin
    logic [Q100_PW-1:0]   p100;
    logic [Q1460_PW-1:0]  p1460;
    logic [Q36524_PW-1:0] p36524;
    p100   = Q100_PW'(s3_q.yoe) * Q100_PW'(Q100_M);
    p1460  = Q1460_PW'(s3_q.n_doe) * Q1460_PW'(Q1460_M);
    p36524 = Q36524_PW'(s3_q.n_doe) * Q36524_PW'(Q36524_M);
    s4_d.func   = s3_q.func;
    s4_d.doe    = DOE_BITS'(s3_q.yoe) * DOE_BITS'(365) + DOE_BITS'(s3_q.yoe[8:2])
                - DOE_BITS'(p100[Q100_K +: 2]) + DOE_BITS'(s3_q.doy);
    s4_d.eday   = ED_BITS'(s3_q.era) * ED_BITS'(ERA_DAYS);
    s4_d.bad    = s3_q.bad;
    s4_d.n_t    = s3_q.n_doe - DOE_BITS'(p1460[Q1460_K +: 7])
                + DOE_BITS'(p36524[Q36524_K +: 3])
                - ((s3_q.n_doe == DOE_BITS'(ERA_LAST)) ? DOE_BITS'(1) : DOE_BITS'(0));
    s4_d.n_doe  = s3_q.n_doe;
    s4_d.n_e400 = YB_BITS'(s3_q.n_era) * YB_BITS'(400);
  end

  // Stage 4 -> 5: final day number with range check; year of era
  always_comb begin
    logic signed [ZW-1:0] z;
    logic                 fits;
    logic [Q365_PW-1:0]   p365;
    z    = ZW'(s4_q.eday) + ZW'(s4_q.doe) - ZW'(DAY_OFS);
    fits = (&z[ZW-1:DN_BITS-1]) || !(|z[ZW-1:DN_BITS-1]);
    p365 = Q365_PW'(s4_q.n_t) * Q365_PW'(Q365_M);
    s5_d.func   = s4_q.func;
    s5_d.derr   = s4_q.bad || !fits;
    s5_d.dn     = s5_d.derr ? '0 : z[DN_BITS-1:0];
    s5_d.n_yoe  = p365[Q365_K +: YOE_BITS];
    s5_d.n_doe  = s4_q.n_doe;
    s5_d.n_e400 = s4_q.n_e400;
  end

  // Stage 5 -> 6: day of year and base year
  always_comb begin
    logic [Q100_PW-1:0] p100;
    p100 = Q100_PW'(s5_q.n_yoe) * Q100_PW'(Q100_M);
    s6_d.func  = s5_q.func;
    s6_d.dn    = s5_q.dn;
    s6_d.derr  = s5_q.derr;
    s6_d.n_doy = DOY_BITS'(s5_q.n_doe - (DOE_BITS'(s5_q.n_yoe) * DOE_BITS'(365)
               + DOE_BITS'(s5_q.n_yoe[8:2]) - DOE_BITS'(p100[Q100_K +: 2])));
    s6_d.n_yb  = s5_q.n_e400 + YB_BITS'(s5_q.n_yoe);
  end

  // Stage 6 -> 7: shifted month
  always_comb begin
    logic [MPX_BITS-1:0] x;
    logic [Q153_PW-1:0]  p153;
    x    = MPX_BITS'(s6_q.n_doy) * MPX_BITS'(5) + MPX_BITS'(2);
    p153 = Q153_PW'(x) * Q153_PW'(Q153_M);
    s7_d.func  = s6_q.func;
    s7_d.dn    = s6_q.dn;
    s7_d.derr  = s6_q.derr;
    s7_d.n_mp  = p153[Q153_K +: MP_BITS];
    s7_d.n_doy = s6_q.n_doy;
    s7_d.n_yb  = s6_q.n_yb;
  end

  // Stage 7 -> 8: day, month, year; pick the direction
  always_comb begin
    logic                       jan_feb;
    logic signed [YB_BITS-1:0]  yfin;
    logic                       yok;
    logic [DOY_BITS-1:0]        dd;
    jan_feb = (s7_q.n_mp >= 4'd10);
    yfin    = s7_q.n_yb + (jan_feb ? YB_BITS'(1) : YB_BITS'(0));
    yok     = (&yfin[YB_BITS-1:YEAR_BITS-1]) || !(|yfin[YB_BITS-1:YEAR_BITS-1]);
    dd      = s7_q.n_doy - month_start(s7_q.n_mp) + DOY_BITS'(1);
    s8_d    = '0;
    if (s7_q.func) begin
      s8_d.err = !yok;
      if (yok) begin
        s8_d.year  = YEAR_W'(yfin[YEAR_BITS-1:0]);
        s8_d.month = jan_feb ? MONTH_W'(s7_q.n_mp - 4'd9) : MONTH_W'(s7_q.n_mp + 4'd3);
        s8_d.day   = DAY_W'(dd);
      end
    end else begin
      s8_d.err = s7_q.derr;
      s8_d.dn  = s7_q.dn;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_in[i];
        end
      end
    end
  end

  // Stage payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
    if (en[1]) s2_q <= s2_d;
    if (en[2]) s3_q <= s3_d;
    if (en[3]) s4_q <= s4_d;
    if (en[4]) s5_q <= s5_d;
    if (en[5]) s6_q <= s6_d;
    if (en[6]) s7_q <= s7_d;
    if (en[7]) s8_q <= s8_d;
  end

  // Result word
  assign out_o.valid          = vld_q[NSTG-1];
  assign out_o.day_number_out = $signed(s8_q.dn);
  assign out_o.year_out       = $signed(s8_q.year);
  assign out_o.month_out      = s8_q.month;
  assign out_o.day_out        = s8_q.day;
  assign out_o.range_error    = s8_q.err;

  // Input must be ready whenever some stage is free
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> in_i.ready)
    else $error("input stalled with a free pipeline stage");

  // Era remainder of the day-count path stays inside one era
  a_doe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (s3_q.n_doe < DOE_BITS'(ERA_DAYS)))
    else $error("day of era out of range");

  // Flagged results carry zeros
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.range_error) |->
      (out_o.day_number_out == '0 && out_o.year_out == '0 &&
       out_o.month_out == '0 && out_o.day_out == '0))
    else $error("range error with nonzero result");

  // A produced date is a legal month and day and has no day number
  a_date_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.month_out != '0) |->
      (out_o.month_out <= 4'd12 && out_o.day_out != '0 &&
       out_o.day_number_out == '0))
    else $error("illegal month or day in result");

endmodule
